>>> rtl/core/fuhp_pkg.sv
`timescale 1ns / 1ps
package fuhp_pkg;
	localparam int MAX_SECTIONS_DEF = 8;
	localparam int SEC_CNT_W = 4;
	localparam int IQ_CNT_W = 16;
	localparam logic [3:0] SUBFRAMES_PER_FRAME = 4'd10;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SECHDR,
		PH_COMPLEN,
		PH_IQ,
		PH_DROP
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_SHORT = 4'd1,
		ST_SUBFRAME = 4'd2,
		ST_SLOT = 4'd3,
		ST_DIRECTION = 4'd4,
		ST_VERSION = 4'd5,
		ST_FILTER = 4'd6,
		ST_SYMBOL = 4'd7,
		ST_TOO_MANY = 4'd8,
		ST_NONE = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		REG_VERSION = 3'd0,
		REG_FILTER_MASK = 3'd1,
		REG_SYMBOLS = 3'd2,
		REG_SLOTS = 3'd3,
		REG_RU_PRBS = 3'd4,
		REG_IQ_WIDTH = 3'd5,
		REG_PARAM_PRESENT = 3'd6,
		REG_LEN_PRESENT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] expected_version;
		logic [15:0] filter_valid_mask;
		logic [6:0] symbols_per_slot;
		logic [4:0] slots_per_subframe;
		logic [8:0] ru_prb_count;
		logic [4:0] iq_width;
		logic comp_param_present;
		logic comp_length_present;
	} cfg_t;

	// result item, 78 bits
	typedef struct packed {
		logic message_done;
		logic [15:0] comp_length;
		logic [8:0] prb_total;
		logic [9:0] first_prb;
		logic use_current_symbol;
		logic all_rbs_used;
		logic [11:0] section_ident;
		logic [5:0] symbol_number;
		logic [5:0] slot_number;
		logic [3:0] subframe_number;
		logic [7:0] frame_number;
		logic [3:0] status;
	} result_t;
endpackage

>>> rtl/core/fronthaul_uplane_header_parser.sv
`timescale 1ns / 1ps
// Takes one message byte per cycle; a result is queued the cycle after its byte.
// Throughput: one byte per cycle, two results per byte at most (descriptor then status).
// A four-entry result queue parts the parser from the output; it takes bytes while
// it has room for two results.
// Reset (arst_n low, asynchronous): parser in header phase, queue empty, registers default.
module fronthaul_uplane_header_parser #(
	parameter int MAX_SECTIONS = fuhp_pkg::MAX_SECTIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata, // data_byte
	input  logic s_tlast, // end_of_message
	output logic m_tvalid,
	input  logic m_tready,
	// status, frame_number, subframe_number, slot_number, symbol_number, section_ident,
	// all_rbs_used, use_current_symbol, first_prb, prb_total, comp_length
	output logic [79:0] m_tdata,
	output logic m_tuser, // message_done
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import fuhp_pkg::*;

	cfg_t cfg_q;
	logic r0v, r1v, room2;
	result_t r0, r1, rd;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{3'd1, 16'd31, 7'd14, 5'd2, 9'd273, 5'd9, 1'b1, 1'b0};
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_VERSION: cfg_q.expected_version <= cfg_data[2:0];
				REG_FILTER_MASK: cfg_q.filter_valid_mask <= cfg_data;
				REG_SYMBOLS: cfg_q.symbols_per_slot <= cfg_data[6:0];
				REG_SLOTS: cfg_q.slots_per_subframe <= cfg_data[4:0];
				REG_RU_PRBS: cfg_q.ru_prb_count <= cfg_data[8:0];
				REG_IQ_WIDTH: cfg_q.iq_width <= cfg_data[4:0];
				REG_PARAM_PRESENT: cfg_q.comp_param_present <= cfg_data[0];
				REG_LEN_PRESENT: cfg_q.comp_length_present <= cfg_data[0];
				default: ;
			endcase
		end
	end

	fuhp_front #(.MAX_SECTIONS(MAX_SECTIONS)) u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(s_tvalid), .in_byte(s_tdata), .in_last(s_tlast), .in_ready(s_tready),
		.res0_valid(r0v), .res0(r0), .res1_valid(r1v), .res1(r1), .q_room2(room2)
	);

	fuhp_queue u_queue (
		.clk, .arst_n, .w0_valid(r0v), .w0(r0), .w1_valid(r1v), .w1(r1),
		.room2, .rd_valid(m_tvalid), .rd, .rd_ready(m_tready)
	);

	assign m_tdata = {3'd0, rd[76:0]};
	assign m_tuser = rd.message_done;

	a_two_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		r1v |-> r0v) else $error("second result without first");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> room2) else $error("byte taken without room");
	a_last_gives_status: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |-> (r1v ? r1.message_done : r0.message_done))
		else $error("status missing on last byte");
endmodule

>>> rtl/core/fuhp_front.sv
`timescale 1ns / 1ps
module fuhp_front #(
	parameter int MAX_SECTIONS = fuhp_pkg::MAX_SECTIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  fuhp_pkg::cfg_t cfg,
	input  logic in_valid,
	input  logic [7:0] in_byte,
	input  logic in_last,
	output logic in_ready,
	// up to two results per byte
	output logic res0_valid,
	output fuhp_pkg::result_t res0,
	output logic res1_valid,
	output fuhp_pkg::result_t res1,
	input  logic q_room2
);
	import fuhp_pkg::*;

	phase_t phase_q, phase_d;
	logic [2:0] idx_q, idx_d;
	logic [IQ_CNT_W-1:0] left_q, left_d;
	logic [SEC_CNT_W-1:0] cnt_q, cnt_d;
	logic [3:0] err_q, err_d;
	logic [31:0] hdr_q, hdr_d;
	logic [47:0] sec_q, sec_d;
	// IQ length product, formed from the last section byte in the same cycle
	logic [IQ_CNT_W-1:0] iq_len;
	logic [8:0] prbs;
	logic [9:0] start;
	logic [6:0] per_prb;
	logic [3:0] herr;
	logic [5:0] slot_w;
	logic fin, go;
	result_t desc, stat;

	assign in_ready = q_room2;
	assign go = in_valid && in_ready;

	// header check on assembled bytes
	always_comb begin
		slot_w = {hdr_d[11:8], hdr_d[7:6]};
		herr = ST_OK;
		if (hdr_d[15:12] >= SUBFRAMES_PER_FRAME) herr = ST_SUBFRAME;
		else if ({1'b0, slot_w} >= {1'b0, cfg.slots_per_subframe} + 7'd0 &&
			7'(slot_w) >= 7'(cfg.slots_per_subframe)) herr = ST_SLOT;
		else if (hdr_d[31]) herr = ST_DIRECTION;
		else if (hdr_d[30:28] != cfg.expected_version) herr = ST_VERSION;
		else if (!cfg.filter_valid_mask[hdr_d[27:24]]) herr = ST_FILTER;
		else if (7'(hdr_d[5:0]) >= cfg.symbols_per_slot) herr = ST_SYMBOL;
	end

	always_comb begin
		prbs = sec_d[23:16] == 8'd0 ? cfg.ru_prb_count : {1'b0, sec_d[23:16]};
		start = sec_d[23:16] == 8'd0 ? 10'd0 : {sec_d[33:32], sec_d[31:24]};
		per_prb = 7'(3 * cfg.iq_width) + 7'(cfg.comp_param_present);
		iq_len = IQ_CNT_W'(prbs) * IQ_CNT_W'(per_prb);
	end

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		left_d = left_q;
		cnt_d = cnt_q;
		err_d = err_q;
		hdr_d = hdr_q;
		sec_d = sec_q;
		fin = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				hdr_d[8*(3-idx_q[1:0]) +: 8] = in_byte;
				idx_d = idx_q + 3'd1;
				if (idx_q == 3'd3) begin
					idx_d = 3'd0;
					sec_d = '0;
					if (herr != ST_OK) begin
						err_d = herr;
						phase_d = PH_DROP;
					end else begin
						phase_d = PH_SECHDR;
					end
				end
			end
			PH_SECHDR, PH_COMPLEN: begin
				sec_d[8*(5-idx_q) +: 8] = in_byte;
				idx_d = idx_q + 3'd1;
				if ((phase_q == PH_SECHDR && idx_q == 3'd3 && !cfg.comp_length_present) ||
					(phase_q == PH_COMPLEN && idx_q == 3'd5)) begin
					left_d = iq_len;
					phase_d = PH_IQ;
					fin = iq_len == '0;
				end else if (phase_q == PH_SECHDR && idx_q == 3'd3) begin
					phase_d = PH_COMPLEN;
				end
			end
			PH_IQ: begin
				if (left_q != '0) left_d = left_q - 1'b1;
				fin = left_q <= IQ_CNT_W'(1);
			end
			default: ;
		endcase
		if (fin) begin
			cnt_d = cnt_q + 1'b1;
			if (cnt_d >= SEC_CNT_W'(MAX_SECTIONS)) begin
				err_d = ST_TOO_MANY;
				phase_d = PH_DROP;
			end else begin
				phase_d = PH_SECHDR;
				idx_d = 3'd0;
			end
		end
	end

	always_comb begin
		desc = '0;
		desc.frame_number = hdr_d[23:16];
		desc.subframe_number = hdr_d[15:12];
		desc.slot_number = {hdr_d[11:8], hdr_d[7:6]};
		desc.symbol_number = hdr_d[5:0];
		desc.section_ident = {sec_d[47:40], sec_d[39:36]};
		desc.all_rbs_used = !sec_d[35];
		desc.use_current_symbol = !sec_d[34];
		desc.first_prb = start;
		desc.prb_total = prbs;
		desc.comp_length = sec_d[15:0];
		stat = '0;
		stat.message_done = 1'b1;
		if (phase_d == PH_HEADER) begin
			stat.status = ST_SHORT;
		end else begin
			stat.frame_number = desc.frame_number;
			stat.subframe_number = desc.subframe_number;
			stat.slot_number = desc.slot_number;
			stat.symbol_number = desc.symbol_number;
			if (err_d != 4'd0) stat.status = err_d;
			else if (cnt_d == '0) stat.status = ST_NONE;
			else stat.status = ST_OK;
		end
		res0_valid = go && (fin || in_last);
		res0 = fin ? desc : stat;
		res1_valid = go && fin && in_last;
		res1 = stat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q <= '0;
			left_q <= '0;
			cnt_q <= '0;
			err_q <= '0;
			hdr_q <= '0;
			sec_q <= '0;
		end else if (go) begin
			if (in_last) begin
				phase_q <= PH_HEADER;
				idx_q <= '0;
				left_q <= '0;
				cnt_q <= '0;
				err_q <= '0;
				hdr_q <= '0;
				sec_q <= '0;
			end else begin
				phase_q <= phase_d;
				idx_q <= idx_d;
				left_q <= left_d;
				cnt_q <= cnt_d;
				err_q <= err_d;
				hdr_q <= hdr_d;
				sec_q <= fin ? '0 : sec_d;
			end
		end
	end
endmodule

>>> rtl/core/fuhp_queue.sv
`timescale 1ns / 1ps
module fuhp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic w0_valid,
	input  fuhp_pkg::result_t w0,
	input  logic w1_valid,
	input  fuhp_pkg::result_t w1,
	output logic room2,
	output logic rd_valid,
	output fuhp_pkg::result_t rd,
	input  logic rd_ready
);
	import fuhp_pkg::*;

	localparam int DEPTH = 4;
	result_t mem_q [DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic pop;
	logic [1:0] wp1;

	assign pop = rd_valid && rd_ready;
	assign rd_valid = cnt_q != 3'd0;
	assign rd = mem_q[rp_q];
	assign room2 = cnt_q <= 3'd2;
	assign wp1 = wp_q + 2'd1;

	always_ff @(posedge clk) begin
		if (w0_valid) mem_q[wp_q] <= w0;
		if (w1_valid) mem_q[wp1] <= w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + 2'(w0_valid) + 2'(w1_valid);
			rp_q <= rp_q + 2'(pop);
			cnt_q <= cnt_q + 3'(w0_valid) + 3'(w1_valid) - 3'(pop);
		end
	end
endmodule
